// ----- sv/mpd_pkg.sv -----
// Shared types and codes for the multipart stream deframer.
// Used by mpd_cell, mpd_window and multipart_stream_deframer_top; no dependencies.
`timescale 1ns / 1ps

package mpd_pkg;

    // Default sizing
    localparam int MAX_BOUNDARY_DEF = 32;
    localparam int WINDOW_DEPTH_DEF = 36;

    // Configuration register indexes
    localparam logic [2:0] REG_BND_WORD0 = 3'd0;
    localparam logic [2:0] REG_BND_WORD1 = 3'd1;
    localparam logic [2:0] REG_BND_WORD2 = 3'd2;
    localparam logic [2:0] REG_BND_WORD3 = 3'd3;
    localparam logic [2:0] REG_BND_LEN   = 3'd4;
    localparam logic [2:0] REG_MAX_HDR   = 3'd5;

    localparam logic [5:0]  BND_LEN_RST = 6'd1;
    localparam logic [15:0] MAX_HDR_RST = 16'd8192;

    // Parser modes
    localparam logic [1:0] PM_SEARCH = 2'd0;
    localparam logic [1:0] PM_AFTER  = 2'd1;
    localparam logic [1:0] PM_HEADER = 2'd2;
    localparam logic [1:0] PM_BODY   = 2'd3;

    // Result kinds
    localparam logic [2:0] K_HDR_BYTE   = 3'd0;
    localparam logic [2:0] K_BODY_BYTE  = 3'd1;
    localparam logic [2:0] K_PART_START = 3'd2;
    localparam logic [2:0] K_HDR_END    = 3'd3;
    localparam logic [2:0] K_PART_END   = 3'd4;
    localparam logic [2:0] K_CLOSED     = 3'd5;
    localparam logic [2:0] K_OVERFLOW   = 3'd6;

    // Delimiter characters
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DASH = 8'h2D;

    typedef struct packed {
        logic       mode;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] out_byte;
    } out_item_t;

    // Window control from the parser
    typedef struct packed {
        logic shift;
        logic clear;
    } win_ctrl_t;

    // Window status, computed on the window as it stands after a push
    typedef struct packed {
        logic       search_hit;
        logic       body_hit;
        logic       hdr_end_hit;
        logic       hdr_valid;
        logic [7:0] hdr_byte;
        logic       body_valid;
        logic [7:0] body_byte;
    } win_stat_t;

endpackage

// ----- sv/mpd_cell.sv -----
// One window cell: holds a byte and its valid bit, compares the byte it is
// about to take against its aligned delimiter byte. Depends on mpd_pkg.
`timescale 1ns / 1ps

module mpd_cell
    import mpd_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF,
    parameter int K            = 0
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  win_ctrl_t                 ctrl,
    input  logic [7:0]                prev_data,
    input  logic                      prev_valid,
    input  logic [MAX_BOUNDARY*8-1:0] boundary,
    input  logic [5:0]                bnd_len,
    output logic [7:0]                data,
    output logic                      valid,
    output logic [7:0]                push_data,
    output logic                      push_valid,
    output logic                      hit
);

    logic [7:0] data_reg;
    logic       valid_reg;
    logic [7:0] expected;
    logic       in_range;

    // Select the delimiter byte aligned to this cell for the current length
    always_comb
    begin
        expected = CH_DASH;
        in_range = 1'b1;
        if (int'(bnd_len) + 3 == K)
        begin
            expected = CH_CR;
        end
        else if (int'(bnd_len) + 2 == K)
        begin
            expected = CH_LF;
        end
        else if (int'(bnd_len) + 1 == K || int'(bnd_len) == K)
        begin
            expected = CH_DASH;
        end
        else if (int'(bnd_len) > K)
        begin
            for (int i = 0; i < MAX_BOUNDARY; i++)
            begin
                if (int'(bnd_len) - 1 - K == i)
                begin
                    expected = boundary[i*8 +: 8];
                end
            end
        end
        else
        begin
            in_range = 1'b0;
        end
    end

    assign push_data  = prev_data;
    assign push_valid = prev_valid;
    assign hit        = !in_range || (prev_data == expected);
    assign data       = data_reg;
    assign valid      = valid_reg;

    // Hold, shift or drop the cell contents
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.clear)
        begin
            valid_reg <= 1'b0;
        end
        else if (ctrl.shift)
        begin
            valid_reg <= prev_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.shift)
        begin
            data_reg <= prev_data;
        end
    end

endmodule

// ----- sv/mpd_window.sv -----
// Sliding byte window built from a row of mpd_cell, with delimiter match
// reduction and release taps. Depends on mpd_pkg and mpd_cell.
`timescale 1ns / 1ps

module mpd_window
    import mpd_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  win_ctrl_t                 ctrl,
    input  logic [7:0]                new_byte,
    input  logic [MAX_BOUNDARY*8-1:0] boundary,
    input  logic [5:0]                bnd_len,
    output win_stat_t                 stat
);

    logic [7:0]              cell_data  [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] cell_valid;
    logic [7:0]              push_data  [WINDOW_DEPTH];
    logic [WINDOW_DEPTH-1:0] push_valid;
    logic [WINDOW_DEPTH-1:0] hit;
    logic [WINDOW_DEPTH-1:0] search_mask;
    logic [WINDOW_DEPTH-1:0] body_mask;
    logic                    search_full;

    // Row of cells, newest byte enters at cell 0
    for (genvar k = 0; k < WINDOW_DEPTH; k++)
    begin : g_cell
        logic [7:0] prev_data;
        logic       prev_valid;

        if (k == 0)
        begin : g_head
            assign prev_data  = new_byte;
            assign prev_valid = 1'b1;
        end
        else
        begin : g_link
            assign prev_data  = cell_data[k-1];
            assign prev_valid = cell_valid[k-1];
        end

        mpd_cell #(
            .MAX_BOUNDARY (MAX_BOUNDARY),
            .K            (k)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .prev_data  (prev_data),
            .prev_valid (prev_valid),
            .boundary   (boundary),
            .bnd_len    (bnd_len),
            .data       (cell_data[k]),
            .valid      (cell_valid[k]),
            .push_data  (push_data[k]),
            .push_valid (push_valid[k]),
            .hit        (hit[k])
        );
    end

    // Reduce cell compares and pick release taps
    always_comb
    begin
        search_full     = 1'b0;
        stat.body_valid = 1'b0;
        stat.body_byte  = 8'h00;
        for (int k = 0; k < WINDOW_DEPTH; k++)
        begin
            search_mask[k] = (k <= int'(bnd_len) + 1);
            body_mask[k]   = (k <= int'(bnd_len) + 3);
            if (k == int'(bnd_len) + 1)
            begin
                search_full = push_valid[k];
            end
            if (k == int'(bnd_len) + 3)
            begin
                stat.body_valid = push_valid[k];
                stat.body_byte  = push_data[k];
            end
        end
        stat.search_hit  = search_full && (&(hit | ~search_mask));
        stat.body_hit    = stat.body_valid && (&(hit | ~body_mask));
        stat.hdr_valid   = push_valid[3];
        stat.hdr_byte    = push_data[3];
        stat.hdr_end_hit = push_valid[3] && push_data[3] == CH_CR && push_data[2] == CH_LF
                           && push_data[1] == CH_CR && push_data[0] == CH_LF;
    end

endmodule

// ----- sv/multipart_stream_deframer_top.sv -----
// Multipart stream deframer: parser state, configuration registers and
// output register around the mpd_window cell row.
// Depends on mpd_pkg, mpd_window and mpd_cell.
//
// Usage: one transaction on in_valid/in_ready carries one data byte
// (mode 0) or an end-of-stream flush (mode 1). Each transaction yields at
// most one result on out_valid/out_ready: header byte, body byte, part
// start, header end, part end, stream closed or header overflow.
// The cfg channel (always ready) writes boundary words 0..3, boundary
// length and the header byte limit by register index; write it only idle.
// A result is registered onto out_data the cycle after its transaction.
// Throughput: one transaction per cycle; each byte is decided by the
// parallel compare across the window cells. The input stalls
// only when the output register is full and out_ready is low.
// Header bytes come out three bytes late; body bytes come out boundary
// length plus three bytes late, so a terminator is never released.
// Reset empties the window, returns to delimiter search and restores the
// register defaults (boundary length 1, header limit 8192).
`timescale 1ns / 1ps

module multipart_stream_deframer_top
    import mpd_pkg::*;
#(
    parameter int MAX_BOUNDARY = MAX_BOUNDARY_DEF,
    parameter int WINDOW_DEPTH = WINDOW_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_data,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [63:0] cfg_data
);

    localparam int LEN_CAP = (MAX_BOUNDARY < WINDOW_DEPTH - 4) ? MAX_BOUNDARY
                                                               : WINDOW_DEPTH - 4;

    logic [63:0] bnd_word_reg [4];
    logic [5:0]  bnd_len_reg;
    logic [15:0] max_hdr_reg;

    logic [1:0]  pmode_reg, pmode_next;
    logic        after_reg, after_next;
    logic [7:0]  first_reg, first_next;
    logic [15:0] hdr_count_reg, hdr_count_next;
    logic        ovf_reg, ovf_next;
    logic        out_valid_reg, out_valid_next;
    out_item_t   out_data_reg, out_data_next;

    logic        accept;
    logic [5:0]  used_len;
    logic [255:0] bnd_flat;
    win_ctrl_t   wctrl;
    win_stat_t   wstat;
    logic        res_valid;
    out_item_t   res;
    logic [15:0] count_inc;

    assign cfg_ready = 1'b1;
    assign in_ready  = !out_valid_reg || out_ready;
    assign accept    = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign bnd_flat  = {bnd_word_reg[3], bnd_word_reg[2], bnd_word_reg[1], bnd_word_reg[0]};

    // Clamp the boundary length to the supported range
    always_comb
    begin
        if (bnd_len_reg == 6'd0)
        begin
            used_len = 6'd1;
        end
        else if (int'(bnd_len_reg) > LEN_CAP)
        begin
            used_len = 6'(LEN_CAP);
        end
        else
        begin
            used_len = bnd_len_reg;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bnd_word_reg[0] <= '0;
            bnd_word_reg[1] <= '0;
            bnd_word_reg[2] <= '0;
            bnd_word_reg[3] <= '0;
            bnd_len_reg     <= BND_LEN_RST;
            max_hdr_reg     <= MAX_HDR_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_BND_WORD0: bnd_word_reg[0] <= cfg_data;
                REG_BND_WORD1: bnd_word_reg[1] <= cfg_data;
                REG_BND_WORD2: bnd_word_reg[2] <= cfg_data;
                REG_BND_WORD3: bnd_word_reg[3] <= cfg_data;
                REG_BND_LEN:   bnd_len_reg     <= cfg_data[5:0];
                REG_MAX_HDR:   max_hdr_reg     <= cfg_data[15:0];
                default:       ;
            endcase
        end
    end

    mpd_window #(
        .MAX_BOUNDARY (MAX_BOUNDARY),
        .WINDOW_DEPTH (WINDOW_DEPTH)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (wctrl),
        .new_byte (in_data.data_byte),
        .boundary (bnd_flat[MAX_BOUNDARY*8-1:0]),
        .bnd_len  (used_len),
        .stat     (wstat)
    );

    assign count_inc = (hdr_count_reg == 16'hFFFF) ? hdr_count_reg : hdr_count_reg + 16'd1;

    // Decide each transaction: parser mode, window control and result
    always_comb
    begin
        pmode_next     = pmode_reg;
        after_next     = after_reg;
        first_next     = first_reg;
        hdr_count_next = hdr_count_reg;
        ovf_next       = ovf_reg;
        wctrl.shift    = 1'b0;
        wctrl.clear    = 1'b0;
        res_valid      = 1'b0;
        res.kind       = K_HDR_BYTE;
        res.out_byte   = 8'h00;

        if (accept)
        begin
            if (in_data.mode)
            begin
                // Flush: close an open part, drop held bytes
                pmode_next  = PM_SEARCH;
                after_next  = 1'b0;
                first_next  = 8'h00;
                wctrl.clear = 1'b1;
                if (pmode_reg == PM_HEADER || pmode_reg == PM_BODY)
                begin
                    res_valid = 1'b1;
                    res.kind  = K_PART_END;
                end
            end
            else
            begin
                case (pmode_reg)
                    PM_SEARCH:
                    begin
                        wctrl.shift = 1'b1;
                        if (wstat.search_hit)
                        begin
                            wctrl.clear = 1'b1;
                            pmode_next  = PM_AFTER;
                            after_next  = 1'b0;
                        end
                    end
                    PM_AFTER:
                    begin
                        if (!after_reg)
                        begin
                            first_next = in_data.data_byte;
                            after_next = 1'b1;
                        end
                        else
                        begin
                            after_next  = 1'b0;
                            wctrl.clear = 1'b1;
                            if (first_reg == CH_DASH && in_data.data_byte == CH_DASH)
                            begin
                                pmode_next = PM_SEARCH;
                                res_valid  = 1'b1;
                                res.kind   = K_CLOSED;
                            end
                            else if (first_reg == CH_CR && in_data.data_byte == CH_LF)
                            begin
                                pmode_next     = PM_HEADER;
                                hdr_count_next = 16'd0;
                                ovf_next       = 1'b0;
                                res_valid      = 1'b1;
                                res.kind       = K_PART_START;
                            end
                            else
                            begin
                                pmode_next = PM_SEARCH;
                            end
                        end
                    end
                    PM_HEADER:
                    begin
                        wctrl.shift = 1'b1;
                        if (wstat.hdr_end_hit)
                        begin
                            wctrl.clear = 1'b1;
                            pmode_next  = PM_BODY;
                            res_valid   = 1'b1;
                            res.kind    = K_HDR_END;
                        end
                        else
                        begin
                            hdr_count_next = count_inc;
                            if (!ovf_reg && count_inc > max_hdr_reg)
                            begin
                                ovf_next  = 1'b1;
                                res_valid = 1'b1;
                                res.kind  = K_OVERFLOW;
                            end
                            else if (!ovf_reg && wstat.hdr_valid)
                            begin
                                res_valid    = 1'b1;
                                res.kind     = K_HDR_BYTE;
                                res.out_byte = wstat.hdr_byte;
                            end
                        end
                    end
                    default:
                    begin
                        wctrl.shift = 1'b1;
                        if (wstat.body_hit)
                        begin
                            wctrl.clear = 1'b1;
                            pmode_next  = PM_AFTER;
                            after_next  = 1'b0;
                            res_valid   = 1'b1;
                            res.kind    = K_PART_END;
                        end
                        else if (wstat.body_valid)
                        begin
                            res_valid    = 1'b1;
                            res.kind     = K_BODY_BYTE;
                            res.out_byte = wstat.body_byte;
                        end
                    end
                endcase
            end
        end
    end

    // Load a new result or drain the output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        if (accept && res_valid)
        begin
            out_valid_next = 1'b1;
            out_data_next  = res;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pmode_reg     <= PM_SEARCH;
            after_reg     <= 1'b0;
            first_reg     <= 8'h00;
            hdr_count_reg <= 16'd0;
            ovf_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pmode_reg     <= pmode_next;
            after_reg     <= after_next;
            first_reg     <= first_next;
            hdr_count_reg <= hdr_count_next;
            ovf_reg       <= ovf_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

endmodule
